// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// check that the condition holds in the cycle after the trigger
`define ASSERT_NEXT(lbl, trig, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error("assertion failed");

`endif

// ----- rtl/kot_pkg.sv -----
`default_nettype none

package kot_pkg;

	localparam int MAX_NAME_LEN = 50;
	localparam int RUN_W = $clog2(MAX_NAME_LEN + 1);
	localparam int KEEP = 5;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	typedef logic [4:0] tok_t;
	typedef logic [7:0] char_t;

	localparam tok_t TOK_IF = 5'd0;
	localparam tok_t TOK_ELSE = 5'd1;
	localparam tok_t TOK_WHILE = 5'd2;
	localparam tok_t TOK_PRINT = 5'd3;
	localparam tok_t TOK_COLON = 5'd4;
	localparam tok_t TOK_SEMI = 5'd5;
	localparam tok_t TOK_LPAREN = 5'd6;
	localparam tok_t TOK_RPAREN = 5'd7;
	localparam tok_t TOK_LBRACE = 5'd8;
	localparam tok_t TOK_RBRACE = 5'd9;
	localparam tok_t TOK_ASSIGN = 5'd10;
	localparam tok_t TOK_EQ = 5'd11;
	localparam tok_t TOK_PLUS = 5'd12;
	localparam tok_t TOK_MINUS = 5'd13;
	localparam tok_t TOK_STAR = 5'd14;
	localparam tok_t TOK_SLASH = 5'd15;
	localparam tok_t TOK_COMMENT = 5'd16;
	localparam tok_t TOK_PERCENT = 5'd17;
	localparam tok_t TOK_NOT = 5'd18;
	localparam tok_t TOK_NE = 5'd19;
	localparam tok_t TOK_GT = 5'd20;
	localparam tok_t TOK_GE = 5'd21;
	localparam tok_t TOK_LT = 5'd22;
	localparam tok_t TOK_LE = 5'd23;
	localparam tok_t TOK_AMP = 5'd24;
	localparam tok_t TOK_BAR = 5'd25;
	localparam tok_t TOK_END = 5'd26;
	localparam tok_t TOK_TOO_LONG = 5'd27;

	localparam char_t CH_NUL = 8'h00;
	localparam char_t CH_BANG = 8'h21;
	localparam char_t CH_PERCENT = 8'h25;
	localparam char_t CH_AMP = 8'h26;
	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_STAR = 8'h2A;
	localparam char_t CH_PLUS = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_SLASH = 8'h2F;
	localparam char_t CH_COLON = 8'h3A;
	localparam char_t CH_SEMI = 8'h3B;
	localparam char_t CH_LT = 8'h3C;
	localparam char_t CH_EQ = 8'h3D;
	localparam char_t CH_GT = 8'h3E;
	localparam char_t CH_LBRACE = 8'h7B;
	localparam char_t CH_BAR = 8'h7C;
	localparam char_t CH_RBRACE = 8'h7D;
	localparam char_t CH_UP_A = 8'h41;
	localparam char_t CH_UP_Z = 8'h5A;
	localparam char_t CH_LO_A = 8'h61;
	localparam char_t CH_LO_Z = 8'h7A;

	typedef enum logic [2:0] {
		PEND_NONE,
		PEND_EQ,
		PEND_SLASH,
		PEND_BANG,
		PEND_GT,
		PEND_LT
	} pend_t;

	typedef struct packed {
		pend_t pend;
		logic [RUN_W-1:0] run_len;
		logic [KEEP-1:0][7:0] letters;
		logic muted;
	} lex_state_t;

	typedef struct packed {
		logic [1:0] count;
		tok_t tok0;
		tok_t tok1;
	} lex_out_t;

	typedef struct packed {
		logic hit;
		tok_t tok;
	} tok_hit_t;

	function automatic logic is_letter(input char_t c);
		return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
	endfunction

	function automatic pend_t held_code(input char_t c);
		pend_t p;
		case (c)
			CH_EQ: p = PEND_EQ;
			CH_SLASH: p = PEND_SLASH;
			CH_BANG: p = PEND_BANG;
			CH_GT: p = PEND_GT;
			CH_LT: p = PEND_LT;
			default: p = PEND_NONE;
		endcase
		return p;
	endfunction

	function automatic tok_hit_t single_code(input char_t c);
		tok_hit_t r;
		r.hit = 1'b1;
		case (c)
			CH_COLON: r.tok = TOK_COLON;
			CH_SEMI: r.tok = TOK_SEMI;
			CH_LPAREN: r.tok = TOK_LPAREN;
			CH_RPAREN: r.tok = TOK_RPAREN;
			CH_LBRACE: r.tok = TOK_LBRACE;
			CH_RBRACE: r.tok = TOK_RBRACE;
			CH_PLUS: r.tok = TOK_PLUS;
			CH_MINUS: r.tok = TOK_MINUS;
			CH_STAR: r.tok = TOK_STAR;
			CH_PERCENT: r.tok = TOK_PERCENT;
			CH_AMP: r.tok = TOK_AMP;
			CH_BAR: r.tok = TOK_BAR;
			default: begin
				r.hit = 1'b0;
				r.tok = TOK_IF;
			end
		endcase
		return r;
	endfunction

	function automatic tok_t pend_single(input pend_t p);
		tok_t t;
		case (p)
			PEND_EQ: t = TOK_ASSIGN;
			PEND_SLASH: t = TOK_SLASH;
			PEND_BANG: t = TOK_NOT;
			PEND_GT: t = TOK_GT;
			PEND_LT: t = TOK_LT;
			default: t = TOK_IF;
		endcase
		return t;
	endfunction

	function automatic tok_t pend_pair(input pend_t p);
		tok_t t;
		case (p)
			PEND_EQ: t = TOK_EQ;
			PEND_SLASH: t = TOK_COMMENT;
			PEND_BANG: t = TOK_NE;
			PEND_GT: t = TOK_GE;
			PEND_LT: t = TOK_LE;
			default: t = TOK_IF;
		endcase
		return t;
	endfunction

	function automatic char_t pend_second(input pend_t p);
		char_t c;
		case (p)
			PEND_SLASH: c = CH_SLASH;
			PEND_EQ, PEND_BANG, PEND_GT, PEND_LT: c = CH_EQ;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	// letters[0] is the first letter of the run
	function automatic tok_hit_t kw_match(input logic [KEEP-1:0][7:0] l,
			input logic [RUN_W-1:0] len);
		tok_hit_t r;
		r.hit = 1'b1;
		if (len == RUN_W'(2) && l[0] == 8'h69 && l[1] == 8'h66) begin
			r.tok = TOK_IF;
		end else if (len == RUN_W'(4) && l[0] == 8'h65 && l[1] == 8'h6C
				&& l[2] == 8'h73 && l[3] == 8'h65) begin
			r.tok = TOK_ELSE;
		end else if (len == RUN_W'(5) && l[0] == 8'h77 && l[1] == 8'h68
				&& l[2] == 8'h69 && l[3] == 8'h6C && l[4] == 8'h65) begin
			r.tok = TOK_WHILE;
		end else if (len == RUN_W'(5) && l[0] == 8'h70 && l[1] == 8'h72
				&& l[2] == 8'h69 && l[3] == 8'h6E && l[4] == 8'h74) begin
			r.tok = TOK_PRINT;
		end else begin
			r.hit = 1'b0;
			r.tok = TOK_IF;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/kot_lex.sv -----
`default_nettype none

module kot_lex (
	input kot_pkg::lex_state_t cur,
	input kot_pkg::char_t c,
	output kot_pkg::lex_state_t nxt,
	output kot_pkg::lex_out_t res
);

	logic done;
	logic [kot_pkg::RUN_W-1:0] len1;
	kot_pkg::tok_hit_t kw;
	kot_pkg::tok_hit_t sgl;
	kot_pkg::tok_t emit_tok;
	logic emit;

	always_comb begin
		nxt = cur;
		res = '0;
		done = 1'b0;
		emit = 1'b0;
		emit_tok = kot_pkg::TOK_IF;
		len1 = cur.run_len + kot_pkg::RUN_W'(1);
		kw = '0;
		sgl = kot_pkg::single_code(c);
		if (cur.muted) begin
			if (c == kot_pkg::CH_NUL) begin
				nxt.muted = 1'b0;
				nxt.run_len = '0;
				nxt.pend = kot_pkg::PEND_NONE;
				res.count = 2'd1;
				res.tok0 = kot_pkg::TOK_END;
			end
		end else begin
			if (cur.pend != kot_pkg::PEND_NONE) begin
				nxt.pend = kot_pkg::PEND_NONE;
				if (c == kot_pkg::pend_second(cur.pend)) begin
					nxt.run_len = '0;
					done = 1'b1;
					res.tok0 = kot_pkg::pend_pair(cur.pend);
				end else begin
					res.tok0 = kot_pkg::pend_single(cur.pend);
				end
				res.count = 2'd1;
			end
			if (!done) begin
				if (kot_pkg::is_letter(c)) begin
					for (int i = 0; i < kot_pkg::KEEP; i++) begin
						if (cur.run_len == kot_pkg::RUN_W'(i))
							nxt.letters[i] = c;
					end
					kw = kot_pkg::kw_match(nxt.letters, len1);
					if (len1 >= kot_pkg::RUN_W'(kot_pkg::MAX_NAME_LEN)) begin
						nxt.run_len = '0;
						nxt.muted = 1'b1;
						emit = 1'b1;
						emit_tok = kot_pkg::TOK_TOO_LONG;
					end else if (kw.hit) begin
						nxt.run_len = '0;
						emit = 1'b1;
						emit_tok = kw.tok;
					end else begin
						nxt.run_len = len1;
					end
				end else begin
					nxt.run_len = '0;
					if (c == kot_pkg::CH_NUL) begin
						emit = 1'b1;
						emit_tok = kot_pkg::TOK_END;
					end else if (kot_pkg::held_code(c) != kot_pkg::PEND_NONE) begin
						nxt.pend = kot_pkg::held_code(c);
					end else if (sgl.hit) begin
						emit = 1'b1;
						emit_tok = sgl.tok;
					end
				end
				// a flushed operator goes first, the new token after it
				if (emit) begin
					if (res.count == 2'd0) begin
						res.tok0 = emit_tok;
						res.count = 2'd1;
					end else begin
						res.tok1 = emit_tok;
						res.count = 2'd2;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/keyword_operator_tokenizer.sv -----
`default_nettype none

// Keyword and operator tokenizer. One character beat is taken every clock cycle
// while the queue has room; the byte is held in an input register, decoded by a
// single pass of logic against the run and held-operator state, and its zero,
// one or two tokens are then pushed into a four-entry result queue. The queue
// drains one token a cycle while token_ready is high: a character that gives two
// tokens (a held operator flushed by another token) fills two queue entries, and
// input stalls only when the queue holds more than two tokens. last marks the
// final token caused by each character.

module keyword_operator_tokenizer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic char_valid,
	output logic char_ready,
	input wire logic [7:0] char_code,
	output logic token_valid,
	input wire logic token_ready,
	output logic [4:0] token_code,
	output logic last
);

	`include "assert_macros.svh"

	logic valid_s1;
	kot_pkg::char_t char_s1;
	logic fire;

	kot_pkg::pend_t pend_q;
	logic [kot_pkg::RUN_W-1:0] run_len_q;
	logic [kot_pkg::KEEP-1:0][7:0] letters_q;
	logic muted_q;

	kot_pkg::lex_state_t cur;
	kot_pkg::lex_state_t nxt;
	kot_pkg::lex_out_t res;

	kot_pkg::tok_t fifo_tok_q [kot_pkg::FIFO_DEPTH];
	logic fifo_last_q [kot_pkg::FIFO_DEPTH];
	logic [kot_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [kot_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [kot_pkg::FIFO_CW-1:0] count_q;
	logic [kot_pkg::FIFO_CW-1:0] push_n;
	logic pop;

	assign fire = valid_s1 && (count_q <= kot_pkg::FIFO_CW'(kot_pkg::FIFO_DEPTH - 2));
	assign char_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && char_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready)
			char_s1 <= char_code;
	end

	assign cur = '{pend: pend_q, run_len: run_len_q, letters: letters_q, muted: muted_q};

	kot_lex u_lex (
		.cur(cur),
		.c(char_s1),
		.nxt(nxt),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= kot_pkg::PEND_NONE;
			run_len_q <= '0;
			muted_q <= 1'b0;
		end else if (fire) begin
			pend_q <= nxt.pend;
			run_len_q <= nxt.run_len;
			muted_q <= nxt.muted;
		end
	end

	// letters beyond the run length are never compared
	always_ff @(posedge clk) begin
		if (fire)
			letters_q <= nxt.letters;
	end

	assign push_n = fire ? kot_pkg::FIFO_CW'(res.count) : '0;
	assign pop = token_valid && token_ready;

	always_ff @(posedge clk) begin
		if (fire && res.count != 2'd0) begin
			fifo_tok_q[wr_ptr_q] <= res.tok0;
			fifo_last_q[wr_ptr_q] <= (res.count == 2'd1);
		end
		if (fire && res.count == 2'd2) begin
			fifo_tok_q[wr_ptr_q + kot_pkg::FIFO_AW'(1)] <= res.tok1;
			fifo_last_q[wr_ptr_q + kot_pkg::FIFO_AW'(1)] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + kot_pkg::FIFO_AW'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + kot_pkg::FIFO_AW'(1);
			count_q <= count_q + push_n - kot_pkg::FIFO_CW'(pop);
		end
	end

	assign token_valid = (count_q != '0);
	assign token_code = fifo_tok_q[rd_ptr_q];
	assign last = fifo_last_q[rd_ptr_q];

	`ASSERT_ALWAYS(a_fifo_bound, count_q <= kot_pkg::FIFO_CW'(kot_pkg::FIFO_DEPTH))
	`ASSERT_ALWAYS(a_mute_no_pend, !muted_q || pend_q == kot_pkg::PEND_NONE)
	`ASSERT_ALWAYS(a_run_below_max, run_len_q < kot_pkg::RUN_W'(kot_pkg::MAX_NAME_LEN))
	`ASSERT_NEXT(a_nul_resets, fire && char_s1 == kot_pkg::CH_NUL, run_len_q == '0 && !muted_q && pend_q == kot_pkg::PEND_NONE)

endmodule

`default_nettype wire
